/* rtl/motion_delta_rescale_with_remainder_assert.svh */
// Assertion macros for the motion delta rescaler.
// Included by the top level; relies on clk and rst_n in the including scope.
`ifndef MOTION_DELTA_RESCALE_WITH_REMAINDER_ASSERT_SVH
`define MOTION_DELTA_RESCALE_WITH_REMAINDER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MDRR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MDRR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mdrr_pkg.sv */
// Shared types and constants for the motion delta rescaler.
// No dependencies; used by mdrr_addsub, mdrr_core and the top level.
package mdrr_pkg;

  localparam int DELTA_W = 32;
  localparam int EXT_W   = 16;
  localparam int OUT_W   = 16;
  localparam int REM_W   = 17;
  localparam int ACC_W   = 49;
  localparam int MAG_W   = 48;
  localparam int CNT_W   = 6;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic REG_REFERENCE_EXTENT = 1'b0;
  localparam logic REG_PRESENT_EXTENT   = 1'b1;

  localparam logic [OUT_W-1:0] SCALED_MAX = 16'h7FFF;
  localparam logic [OUT_W-1:0] SCALED_MIN = 16'h8000;

  typedef struct packed {
    logic             start;
    logic             take;
    logic [DELTA_W-1:0] delta;
    logic [EXT_W-1:0] ref_ext;
    logic [EXT_W-1:0] pres_ext;
  } core_cmd_t;

  typedef struct packed {
    logic             busy;
    logic             res_valid;
    logic [OUT_W-1:0] res;
  } core_stat_t;

endpackage

/* rtl/mdrr_addsub.sv */
// Shared 49-bit adder/subtractor used for the multiply, sign-fold and divide steps.
// Depends on mdrr_pkg for the datapath width.
module mdrr_addsub (
  input  logic [mdrr_pkg::ACC_W-1:0] a,
  input  logic [mdrr_pkg::ACC_W-1:0] b,
  input  logic                       sub,
  output logic [mdrr_pkg::ACC_W-1:0] sum
);

  logic [mdrr_pkg::ACC_W-1:0] b_op;

  assign b_op = sub ? ~b : b;
  assign sum  = a + b_op + {{(mdrr_pkg::ACC_W-1){1'b0}}, sub};

endmodule

/* rtl/mdrr_core.sv */
// Sequencer and datapath: shift-add multiply, sign fold, restoring divide,
// saturation and remainder carry. Depends on mdrr_pkg and mdrr_addsub.
module mdrr_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mdrr_pkg::core_cmd_t  cmd,
  output mdrr_pkg::core_stat_t stat
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_ABS  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_SAT  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  localparam int AW = mdrr_pkg::ACC_W;
  localparam int RW = mdrr_pkg::REM_W;
  localparam int EW = mdrr_pkg::EXT_W;
  localparam int OW = mdrr_pkg::OUT_W;
  localparam int MW = mdrr_pkg::MAG_W;
  localparam int CW = mdrr_pkg::CNT_W;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] acc_r, acc_nxt;
  logic [AW-1:0] mcand_r, mcand_nxt;
  logic [EW-1:0] mplier_r, mplier_nxt;
  logic [EW-1:0] div_r, div_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic          neg_r, neg_nxt;
  logic [OW-1:0] res_r, res_nxt;
  logic [RW-1:0] crem_r, crem_nxt;

  logic [AW-1:0] alu_a, alu_b, alu_sum;
  logic          alu_sub;

  logic [RW-1:0] div_win;
  logic          div_take;
  logic [MW-1:0] quo;
  logic          big_pos, big_neg;

  mdrr_addsub u_addsub (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .sum (alu_sum)
  );

  assign div_win  = {rem_r[RW-2:0], acc_r[MW-1]};
  assign div_take = ~alu_sum[AW-1];
  assign quo      = acc_r[MW-1:0];
  assign big_pos  = |quo[MW-1:OW-1];
  assign big_neg  = (|quo[MW-1:OW]) | (quo[OW-1] & (|quo[OW-2:0]));

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    div_nxt    = div_r;
    rem_nxt    = rem_r;
    neg_nxt    = neg_r;
    res_nxt    = res_r;
    crem_nxt   = crem_r;
    alu_a      = acc_r;
    alu_b      = '0;
    alu_sub    = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (cmd.start) begin
          if ((cmd.ref_ext == '0) || (cmd.pres_ext == '0)) begin
            // disabled scaling: zero result, remainder untouched
            res_nxt   = '0;
            state_nxt = ST_FIN;
          end else begin
            acc_nxt    = {{(AW-RW){crem_r[RW-1]}}, crem_r};
            mcand_nxt  = {{(AW-mdrr_pkg::DELTA_W){cmd.delta[mdrr_pkg::DELTA_W-1]}},
                          cmd.delta};
            mplier_nxt = cmd.ref_ext;
            div_nxt    = cmd.pres_ext;
            cnt_nxt    = CW'(EW - 1);
            state_nxt  = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        alu_a      = acc_r;
        alu_b      = mcand_r & {AW{mplier_r[0]}};
        acc_nxt    = alu_sum;
        mcand_nxt  = {mcand_r[AW-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[EW-1:1]};
        cnt_nxt    = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_ABS;
        end
      end
      ST_ABS: begin
        // fold the dividend to its magnitude, keep the sign
        alu_a   = '0;
        alu_b   = acc_r;
        alu_sub = 1'b1;
        neg_nxt = acc_r[AW-1];
        if (acc_r[AW-1]) begin
          acc_nxt = alu_sum;
        end
        rem_nxt   = '0;
        cnt_nxt   = CW'(MW - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        alu_a   = {{(AW-RW){1'b0}}, div_win};
        alu_b   = {{(AW-EW){1'b0}}, div_r};
        alu_sub = 1'b1;
        rem_nxt = div_take ? alu_sum[RW-1:0] : div_win;
        acc_nxt = {1'b0, acc_r[MW-2:0], div_take};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_SAT;
        end
      end
      ST_SAT: begin
        if (neg_r) begin
          res_nxt  = big_neg ? mdrr_pkg::SCALED_MIN : (~quo[OW-1:0] + 1'b1);
          crem_nxt = ~rem_r + 1'b1;
        end else begin
          res_nxt  = big_pos ? mdrr_pkg::SCALED_MAX : quo[OW-1:0];
          crem_nxt = rem_r;
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (cmd.take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      crem_r  <= '0;
    end else begin
      state_r <= state_nxt;
      crem_r  <= crem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    div_r    <= div_nxt;
    rem_r    <= rem_nxt;
    neg_r    <= neg_nxt;
    res_r    <= res_nxt;
  end

  assign stat.busy      = (state_r != ST_IDLE);
  assign stat.res_valid = (state_r == ST_FIN);
  assign stat.res       = res_r;

endmodule

/* rtl/motion_delta_rescale_with_remainder.sv */
// Each beat steps through multiply, sign fold, divide and saturate, then hands off
// into the output register; an extent at zero skips straight to the handoff. No new
// beat is taken until the last one is handed off, and the multiply, sign fold and divide
// share the single 49-bit adder; a stalled output beat holds off the input.
// Reset (synchronous, active low): both extents to 1, carried remainder to 0,
// no output pending.
module motion_delta_rescale_with_remainder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mdrr_pkg::DELTA_W-1:0]  in_motion_delta,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mdrr_pkg::OUT_W-1:0]    out_scaled_delta,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mdrr_pkg::PADDR_W-1:0]  paddr,
  input  logic [mdrr_pkg::PDATA_W-1:0]  pwdata,
  output logic [mdrr_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

`include "motion_delta_rescale_with_remainder_assert.svh"

  localparam int EW = mdrr_pkg::EXT_W;

  logic [EW-1:0]             ref_ext_r, ref_ext_nxt;
  logic [EW-1:0]             pres_ext_r, pres_ext_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [mdrr_pkg::OUT_W-1:0] out_data_r, out_data_nxt;

  logic                      reg_wr;
  logic                      reg_idx;
  logic                      out_free;

  mdrr_pkg::core_cmd_t  cmd;
  mdrr_pkg::core_stat_t stat;

  mdrr_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .stat  (stat)
  );

  assign pready  = 1'b1;
  assign reg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = paddr[2];

  always_comb begin
    ref_ext_nxt  = ref_ext_r;
    pres_ext_nxt = pres_ext_r;
    if (reg_wr) begin
      case (reg_idx)
        mdrr_pkg::REG_REFERENCE_EXTENT: ref_ext_nxt  = pwdata[EW-1:0];
        mdrr_pkg::REG_PRESENT_EXTENT:   pres_ext_nxt = pwdata[EW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mdrr_pkg::REG_REFERENCE_EXTENT: prdata = {{(mdrr_pkg::PDATA_W-EW){1'b0}}, ref_ext_r};
      mdrr_pkg::REG_PRESENT_EXTENT:   prdata = {{(mdrr_pkg::PDATA_W-EW){1'b0}}, pres_ext_r};
      default:                        prdata = '0;
    endcase
  end

  // output register frees up when empty or its beat is taken this cycle
  assign out_free = ~out_valid_r | ~out_stall;

  assign in_stall     = stat.busy;
  assign cmd.start    = in_valid & ~stat.busy;
  assign cmd.take     = stat.res_valid & out_free;
  assign cmd.delta    = in_motion_delta;
  assign cmd.ref_ext  = ref_ext_r;
  assign cmd.pres_ext = pres_ext_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_free) begin
      out_valid_nxt = stat.res_valid;
      out_data_nxt  = stat.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_ext_r   <= {{(EW-1){1'b0}}, 1'b1};
      pres_ext_r  <= {{(EW-1){1'b0}}, 1'b1};
      out_valid_r <= 1'b0;
    end else begin
      ref_ext_r   <= ref_ext_nxt;
      pres_ext_r  <= pres_ext_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_scaled_delta = out_data_r;

  `MDRR_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
    "core not busy after an accepted beat")
  `MDRR_ASSERT_NEXT(a_result_lands, stat.res_valid && out_free, out_valid,
    "finished result did not reach the output register")
  `MDRR_ASSERT_NOW(a_idle_no_result, !in_stall, !stat.res_valid,
    "idle core still shows a pending result")

endmodule

/* test/motion_delta_rescale_with_remainder_tb.sv */
// Self-checking bench for motion_delta_rescale_with_remainder: motion beats, extent writes.
// Predicts each scaled delta and carried remainder in a scoreboard class; needs mdrr_pkg.
module motion_delta_rescale_with_remainder_tb;

  localparam int EXT_W   = mdrr_pkg::EXT_W;
  localparam int OUT_W   = mdrr_pkg::OUT_W;
  localparam int DELTA_W = mdrr_pkg::DELTA_W;
  localparam int PADDR_W = mdrr_pkg::PADDR_W;
  localparam int PDATA_W = mdrr_pkg::PDATA_W;

  class motion_rescale_model;
    logic [EXT_W-1:0] ref_ext;
    logic [EXT_W-1:0] pres_ext;
    longint           carry;
    logic [OUT_W-1:0] expected_deltas[$];
    int               mismatches;
    int               matched;
    int               saturated;
    int               disabled_hits;
    int               motions;

    function new();
      ref_ext = 16'd1;
      pres_ext = 16'd1;
      carry = 0;
    endfunction

    function void write_extent(logic idx, logic [PDATA_W-1:0] value);
      if (idx == mdrr_pkg::REG_REFERENCE_EXTENT) ref_ext = value[EXT_W-1:0];
      else pres_ext = value[EXT_W-1:0];
    endfunction

    function void note_motion(logic [DELTA_W-1:0] raw);
      longint d, num, q;
      logic [OUT_W-1:0] res;
      motions++;
      if (ref_ext == '0 || pres_ext == '0) begin
        // hold the remainder
        res = '0;
        disabled_hits++;
      end else begin
        d = longint'($signed(raw));
        num = d * longint'(ref_ext) + carry;
        q = num / longint'(pres_ext);
        carry = num % longint'(pres_ext);
        if (q > 32767) begin
          res = mdrr_pkg::SCALED_MAX;
          saturated++;
        end else if (q < -32768) begin
          res = mdrr_pkg::SCALED_MIN;
          saturated++;
        end else begin
          res = q[OUT_W-1:0];
        end
      end
      expected_deltas.push_back(res);
    endfunction

    function void check_scaled(logic [OUT_W-1:0] actual);
      logic [OUT_W-1:0] want;
      if (expected_deltas.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected scaled_delta beat %0d", $time, $signed(actual));
        return;
      end
      want = expected_deltas.pop_front();
      if (actual !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] scaled_delta mismatch: expected %0d, got %0d", $time,
                   $signed(want), $signed(actual));
      end else begin
        matched++;
      end
    endfunction

    function int pending();
      return expected_deltas.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [DELTA_W-1:0] in_motion_delta = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [OUT_W-1:0]   out_scaled_delta;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  motion_rescale_model model = new();
  int                  cfg_writes;
  int                  cyc;
  int                  stall_left;
  int                  stall_mode;

  motion_delta_rescale_with_remainder dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_motion_delta(in_motion_delta),
    .out_valid(out_valid), .out_stall(out_stall), .out_scaled_delta(out_scaled_delta),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver stall: switch between clear, light, heavy and periodic stretches.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(40, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((cyc % 7) < 3);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) model.note_motion(in_motion_delta);
      if (out_valid && !out_stall) model.check_scaled(out_scaled_delta);
    end
  end

  task automatic write_extent_reg(input logic idx, input logic [PDATA_W-1:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    model.write_extent(idx, value);
    cfg_writes++;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Drain all results before touching the extents.
  task automatic set_extents(input int ref_val, input int pres_val);
    while (model.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    write_extent_reg(mdrr_pkg::REG_REFERENCE_EXTENT, PDATA_W'(ref_val));
    write_extent_reg(mdrr_pkg::REG_PRESENT_EXTENT, PDATA_W'(pres_val));
  endtask

  task automatic send_motion(input logic [DELTA_W-1:0] delta);
    in_valid <= 1'b1;
    in_motion_delta <= delta;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause_sender(input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [DELTA_W-1:0] pick_motion();
    longint b;
    int     sel;
    sel = $urandom_range(0, 9);
    if (sel <= 4) return DELTA_W'($signed($urandom_range(0, 600)) - 300);
    if (sel <= 6) return DELTA_W'($signed($urandom_range(0, 140000)) - 70000);
    if (sel == 7) return $urandom();
    if (sel == 8) begin
      case ($urandom_range(0, 5))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'hFFFF_FFFF;
        3: return 32'h0000_0001;
        4: return 32'h0000_0000;
        default: return 32'h0000_8000;
      endcase
    end
    // aim near the saturation boundary for the current ratio
    if (model.ref_ext == '0) return DELTA_W'($urandom_range(0, 15));
    b = (longint'(32767) * longint'(model.pres_ext)) / longint'(model.ref_ext);
    b = b + longint'($urandom_range(0, 4)) - 2;
    if ($urandom_range(0, 1) == 1) b = -b - 1;
    return b[DELTA_W-1:0];
  endfunction

  task automatic run_random_phase(input int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_motion(pick_motion());
        sent++;
      end
      if ($urandom_range(0, 4) == 0) pause_sender($urandom_range(20, 90));
      else pause_sender($urandom_range(0, 6));
    end
    pause_sender(1);
  endtask

  initial begin
    logic [DELTA_W-1:0] edges[$];
    int                 kind;
    int                 r;
    int                 p;

    edges = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_7FFF, 32'h0000_8000,
              32'hFFFF_8000, 32'hFFFF_7FFF, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h5555_5555, 32'hAAAA_AAAA};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset extents, full-range and boundary deltas, back to back.
    foreach (edges[i]) send_motion(edges[i]);
    pause_sender(1);

    // Fractional ratio: remainder carries from beat to beat.
    set_extents(3, 7);
    send_motion(32'd1);
    send_motion(32'd1);
    send_motion(32'd1);
    pause_sender(3);
    send_motion(-32'sd1);
    send_motion(-32'sd5);
    pause_sender(1);

    // Large remainder left behind, then a much smaller divisor.
    set_extents(65534, 65535);
    send_motion(32'd1);
    pause_sender(1);
    set_extents(65534, 2);
    send_motion(32'd0);
    send_motion(-32'sd1);
    pause_sender(1);

    // Either extent zero: result zero, remainder held.
    set_extents(0, 9);
    send_motion(32'd1000);
    send_motion(32'h8000_0000);
    pause_sender(1);
    set_extents(5, 0);
    send_motion(32'h7FFF_FFFF);
    send_motion(32'd3);
    pause_sender(1);

    for (int ph = 0; ph < 10; ph++) begin
      kind = (ph < 3) ? ph : $urandom_range(0, 6);
      case (kind)
        0: begin r = 65535; p = 65535; end
        1: begin r = 65535; p = 1; end
        2: begin r = 1; p = 65535; end
        3: begin r = 0; p = $urandom_range(0, 65535); end
        4: begin r = $urandom_range(1, 65535); p = 0; end
        5: begin r = $urandom_range(1, 65535); p = $urandom_range(1, 65535); end
        default: begin r = $urandom_range(1, 16); p = $urandom_range(1, 16); end
      endcase
      set_extents(r, p);
      run_random_phase(80);
    end

    while (model.pending() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("Covered %0d motion beats over %0d extent writes: %0d matched, %0d saturated,",
             model.motions, cfg_writes, model.matched, model.saturated);
    $display("%0d with an extent at zero, %0d mismatches.", model.disabled_hits,
             model.mismatches);
    if (model.mismatches == 0 && model.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("Timeout: %0d results still outstanding", model.pending());
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/mdrr_pkg.sv
rtl/mdrr_addsub.sv
rtl/mdrr_core.sv
rtl/motion_delta_rescale_with_remainder.sv
test/motion_delta_rescale_with_remainder_tb.sv
